// File: rtl/core/lrpg_pkg.sv
// Shared widths, types and command/status structs of the line raster point generator.
package lrpg_pkg;

  localparam int FIELD_BITS = 6;
  localparam int COORD_BITS = 6;
  localparam int SPAN_BITS  = COORD_BITS + 1;
  localparam int NSPAN_BITS = COORD_BITS + 2;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int E2_BITS    = ERR_BITS + 1;

  typedef logic signed [FIELD_BITS-1:0] field_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SPAN_BITS-1:0]  span_t;
  typedef logic signed [NSPAN_BITS-1:0] nspan_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;
  typedef logic signed [E2_BITS-1:0]    e2_t;

  typedef struct packed {
    logic load;
    logic step;
  } lrpg_cmd_t;

  typedef struct packed {
    logic done;
  } lrpg_stat_t;

endpackage

// File: rtl/core/line_raster_point_generator.sv
// Top level of the line raster point generator: controller plus datapath.
//
// Input channel: one beat carries a segment (start_x, start_y, end_x, end_y),
// accepted when in_valid is high and in_stall is low. Output channel: one
// beat per raster point (point_x, point_y, last_point), taken when out_valid
// is high and out_stall is low; last_point marks the second endpoint.
// The first point is presented in the cycle after the segment beat.
// A segment has N = max(|dx|, |dy|) + 1 points (1 to 64), issued one point
// per cycle from the Bresenham step unit while out_stall is low.
// in_stall stays high after the segment beat until the last point is taken,
// so one segment is worked at a time.
// When the receiver stalls, the current point holds steady on the outputs
// and the error and coordinate registers do not advance.
// Reset (rst, synchronous, active high) returns the controller to idle,
// drops out_valid and drops in_stall; no clearing pass is needed.
module line_raster_point_generator (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  lrpg_pkg::field_t start_x,
  input  lrpg_pkg::field_t start_y,
  input  lrpg_pkg::field_t end_x,
  input  lrpg_pkg::field_t end_y,
  output logic             out_valid,
  input  logic             out_stall,
  output lrpg_pkg::field_t point_x,
  output lrpg_pkg::field_t point_y,
  output logic             last_point
);
  import lrpg_pkg::*;

  lrpg_cmd_t  cmd;
  lrpg_stat_t stat;

  lrpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lrpg_datapath u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .stat       (stat),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .point_x    (point_x),
    .point_y    (point_y),
    .last_point (last_point)
  );

  // No new segment may be taken while points of the current one are pending.
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("segment accepted while a run is in progress");

  // An accepted segment always presents its first point in the next cycle.
  a_first_point: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("no point after an accepted segment");

  // The run ends right after its last point is taken.
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_point) |=> !out_valid)
    else $error("points continue after the last point");

  // A point that is not the last one is followed by another point.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_point) |=> out_valid)
    else $error("run stopped before its last point");

endmodule

// File: rtl/core/lrpg_ctrl.sv
// Controller state machine: accepts a segment, then paces the point beats.
module lrpg_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  lrpg_pkg::lrpg_stat_t   stat,
  output lrpg_pkg::lrpg_cmd_t    cmd
);
  import lrpg_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;
  logic take;

  assign in_stall  = (state == ST_RUN);
  assign out_valid = (state == ST_RUN);
  assign take      = (state == ST_RUN) && !out_stall;

  always_comb begin
    cmd.load = 1'b0;
    cmd.step = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (take) begin
          if (stat.done) begin
            state_next = ST_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/lrpg_datapath.sv
// Datapath: endpoint registers, spans, Bresenham error and the current point.
module lrpg_datapath (
  input  logic                 clk,
  input  lrpg_pkg::lrpg_cmd_t  cmd,
  output lrpg_pkg::lrpg_stat_t stat,
  input  lrpg_pkg::field_t     start_x,
  input  lrpg_pkg::field_t     start_y,
  input  lrpg_pkg::field_t     end_x,
  input  lrpg_pkg::field_t     end_y,
  output lrpg_pkg::field_t     point_x,
  output lrpg_pkg::field_t     point_y,
  output logic                 last_point
);
  import lrpg_pkg::*;

  coord_t cur_x, cur_y, goal_x, goal_y;
  span_t  span_x;
  nspan_t neg_span_y;
  logic   step_x_neg, step_y_neg;
  err_t   error_acc;

  coord_t sx, sy, gx, gy;
  span_t  diff_x, diff_y, abs_x, abs_y;
  e2_t    e2;
  logic   move_x, move_y;
  err_t   error_next;

  // Only the low COORD_BITS of each input field take part.
  assign sx = coord_t'(start_x[COORD_BITS-1:0]);
  assign sy = coord_t'(start_y[COORD_BITS-1:0]);
  assign gx = coord_t'(end_x[COORD_BITS-1:0]);
  assign gy = coord_t'(end_y[COORD_BITS-1:0]);

  assign diff_x = span_t'(gx) - span_t'(sx);
  assign diff_y = span_t'(gy) - span_t'(sy);
  assign abs_x  = diff_x[SPAN_BITS-1] ? -diff_x : diff_x;
  assign abs_y  = diff_y[SPAN_BITS-1] ? -diff_y : diff_y;

  assign e2     = {error_acc, 1'b0};
  assign move_x = (e2 >= e2_t'(neg_span_y));
  assign move_y = (e2 <= e2_t'(span_x));

  always_comb begin
    error_next = error_acc;
    if (move_x) begin
      error_next = error_next + err_t'(neg_span_y);
    end
    if (move_y) begin
      error_next = error_next + err_t'(span_x);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x      <= sx;
      cur_y      <= sy;
      goal_x     <= gx;
      goal_y     <= gy;
      span_x     <= abs_x;
      neg_span_y <= -nspan_t'(abs_y);
      step_x_neg <= !(sx < gx);
      step_y_neg <= !(sy < gy);
      error_acc  <= err_t'(abs_x) - err_t'(abs_y);
    end else if (cmd.step) begin
      error_acc <= error_next;
      if (move_x) begin
        cur_x <= step_x_neg ? cur_x - coord_t'(1) : cur_x + coord_t'(1);
      end
      if (move_y) begin
        cur_y <= step_y_neg ? cur_y - coord_t'(1) : cur_y + coord_t'(1);
      end
    end
  end

  assign stat.done  = (cur_x == goal_x) && (cur_y == goal_y);
  assign point_x    = field_t'(cur_x);
  assign point_y    = field_t'(cur_y);
  assign last_point = stat.done;

endmodule
